### src/cpualu_pkg.sv
// Package: operation codes, flag positions and shared types of the CPU ALU.
`timescale 1ns / 1ps
`default_nettype none
package cpualu_pkg;

  // Operation codes
  localparam logic [5:0] OP_ADC   = 6'd0;
  localparam logic [5:0] OP_SBC   = 6'd1;
  localparam logic [5:0] OP_AND   = 6'd2;
  localparam logic [5:0] OP_ORA   = 6'd3;
  localparam logic [5:0] OP_EOR   = 6'd4;
  localparam logic [5:0] OP_BIT   = 6'd5;
  localparam logic [5:0] OP_CMP   = 6'd6;
  localparam logic [5:0] OP_CPX   = 6'd7;
  localparam logic [5:0] OP_CPY   = 6'd8;
  localparam logic [5:0] OP_LDA   = 6'd9;
  localparam logic [5:0] OP_LDX   = 6'd10;
  localparam logic [5:0] OP_LDY   = 6'd11;
  localparam logic [5:0] OP_ASL_A = 6'd12;
  localparam logic [5:0] OP_ASL_M = 6'd13;
  localparam logic [5:0] OP_LSR_A = 6'd14;
  localparam logic [5:0] OP_LSR_M = 6'd15;
  localparam logic [5:0] OP_INC_M = 6'd16;
  localparam logic [5:0] OP_DEC_M = 6'd17;
  localparam logic [5:0] OP_INX   = 6'd18;
  localparam logic [5:0] OP_INY   = 6'd19;
  localparam logic [5:0] OP_DEX   = 6'd20;
  localparam logic [5:0] OP_DEY   = 6'd21;
  localparam logic [5:0] OP_CLC   = 6'd22;
  localparam logic [5:0] OP_CLD   = 6'd23;
  localparam logic [5:0] OP_CLI   = 6'd24;
  localparam logic [5:0] OP_CLV   = 6'd25;
  localparam logic [5:0] OP_BPL   = 6'd26;
  localparam logic [5:0] OP_BMI   = 6'd27;
  localparam logic [5:0] OP_BVC   = 6'd28;
  localparam logic [5:0] OP_BVS   = 6'd29;
  localparam logic [5:0] OP_BCC   = 6'd30;
  localparam logic [5:0] OP_BCS   = 6'd31;
  localparam logic [5:0] OP_BNE   = 6'd32;
  localparam logic [5:0] OP_BEQ   = 6'd33;

  // Status bit positions: N V 1 B D I Z C
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_U = 5;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [7:0] STATUS_RESET = 8'h20;

  // Architectural registers
  typedef struct packed {
    logic [7:0] accum;
    logic [7:0] index_x;
    logic [7:0] index_y;
    logic [7:0] status;
  } arch_state_t;

  // Outcome of one request
  typedef struct packed {
    logic [7:0] result;
    logic       write_memory;
    logic       branch_taken;
    logic [7:0] status_out;
  } exec_res_t;

endpackage
`default_nettype wire

### src/cpualu_exec.sv
// Execute logic: one operation against the register file, result and new state.
`timescale 1ns / 1ps
`default_nettype none
module cpualu_exec (
  input  wire logic [5:0]               i_mode,
  input  wire logic [7:0]               i_operand,
  input  wire cpualu_pkg::arch_state_t  i_state,
  output cpualu_pkg::arch_state_t       o_state,
  output cpualu_pkg::exec_res_t         o_res
);

  logic [7:0] add_a;
  logic [7:0] add_b;
  logic       add_cin;
  logic [8:0] add_sum;
  logic [7:0] res;
  logic       wr;
  logic       br;
  logic [7:0] p;
  cpualu_pkg::arch_state_t st;

  // Shared adder: ADC, SBC (A + ~M + C) and compares (reg + ~M + 1)
  always_comb begin
    case (i_mode)
      cpualu_pkg::OP_CPX: add_a = i_state.index_x;
      cpualu_pkg::OP_CPY: add_a = i_state.index_y;
      default:            add_a = i_state.accum;
    endcase
    add_b = (i_mode == cpualu_pkg::OP_ADC) ? i_operand : ~i_operand;
    add_cin = ((i_mode == cpualu_pkg::OP_ADC) || (i_mode == cpualu_pkg::OP_SBC)) ?
              i_state.status[cpualu_pkg::FLAG_C] : 1'b1;
    add_sum = {1'b0, add_a} + {1'b0, add_b} + {8'd0, add_cin};
  end

  // Operation decode and flag update
  always_comb begin
    st  = i_state;
    p   = i_state.status;
    res = '0;
    wr  = 1'b0;
    br  = 1'b0;
    case (i_mode)
      cpualu_pkg::OP_ADC, cpualu_pkg::OP_SBC: begin
        res = add_sum[7:0];
        st.accum = res;
        p[cpualu_pkg::FLAG_C] = add_sum[8];
        p[cpualu_pkg::FLAG_V] = (add_a[7] ^ res[7]) & (add_b[7] ^ res[7]);
      end
      cpualu_pkg::OP_AND: begin
        res = i_state.accum & i_operand;
        st.accum = res;
      end
      cpualu_pkg::OP_ORA: begin
        res = i_state.accum | i_operand;
        st.accum = res;
      end
      cpualu_pkg::OP_EOR: begin
        res = i_state.accum ^ i_operand;
        st.accum = res;
      end
      cpualu_pkg::OP_BIT: begin
        res = i_state.accum & i_operand;
      end
      cpualu_pkg::OP_CMP, cpualu_pkg::OP_CPX, cpualu_pkg::OP_CPY: begin
        res = add_sum[7:0];
        p[cpualu_pkg::FLAG_C] = add_sum[8];
      end
      cpualu_pkg::OP_LDA: begin
        res = i_operand;
        st.accum = res;
      end
      cpualu_pkg::OP_LDX: begin
        res = i_operand;
        st.index_x = res;
      end
      cpualu_pkg::OP_LDY: begin
        res = i_operand;
        st.index_y = res;
      end
      cpualu_pkg::OP_ASL_A: begin
        res = {i_state.accum[6:0], 1'b0};
        st.accum = res;
        p[cpualu_pkg::FLAG_C] = i_state.accum[7];
      end
      cpualu_pkg::OP_ASL_M: begin
        res = {i_operand[6:0], 1'b0};
        wr = 1'b1;
        p[cpualu_pkg::FLAG_C] = i_operand[7];
      end
      cpualu_pkg::OP_LSR_A: begin
        res = {1'b0, i_state.accum[7:1]};
        st.accum = res;
        p[cpualu_pkg::FLAG_C] = i_state.accum[0];
      end
      cpualu_pkg::OP_LSR_M: begin
        res = {1'b0, i_operand[7:1]};
        wr = 1'b1;
        p[cpualu_pkg::FLAG_C] = i_operand[0];
      end
      cpualu_pkg::OP_INC_M: begin
        res = i_operand + 8'd1;
        wr = 1'b1;
      end
      cpualu_pkg::OP_DEC_M: begin
        res = i_operand - 8'd1;
        wr = 1'b1;
      end
      cpualu_pkg::OP_INX: begin
        res = i_state.index_x + 8'd1;
        st.index_x = res;
      end
      cpualu_pkg::OP_INY: begin
        res = i_state.index_y + 8'd1;
        st.index_y = res;
      end
      cpualu_pkg::OP_DEX: begin
        res = i_state.index_x - 8'd1;
        st.index_x = res;
      end
      cpualu_pkg::OP_DEY: begin
        res = i_state.index_y - 8'd1;
        st.index_y = res;
      end
      cpualu_pkg::OP_CLC: p[cpualu_pkg::FLAG_C] = 1'b0;
      cpualu_pkg::OP_CLD: p[cpualu_pkg::FLAG_D] = 1'b0;
      cpualu_pkg::OP_CLI: p[cpualu_pkg::FLAG_I] = 1'b0;
      cpualu_pkg::OP_CLV: p[cpualu_pkg::FLAG_V] = 1'b0;
      cpualu_pkg::OP_BPL: br = ~i_state.status[cpualu_pkg::FLAG_N];
      cpualu_pkg::OP_BMI: br =  i_state.status[cpualu_pkg::FLAG_N];
      cpualu_pkg::OP_BVC: br = ~i_state.status[cpualu_pkg::FLAG_V];
      cpualu_pkg::OP_BVS: br =  i_state.status[cpualu_pkg::FLAG_V];
      cpualu_pkg::OP_BCC: br = ~i_state.status[cpualu_pkg::FLAG_C];
      cpualu_pkg::OP_BCS: br =  i_state.status[cpualu_pkg::FLAG_C];
      cpualu_pkg::OP_BNE: br = ~i_state.status[cpualu_pkg::FLAG_Z];
      cpualu_pkg::OP_BEQ: br =  i_state.status[cpualu_pkg::FLAG_Z];
      default: ;
    endcase

    // N and Z follow the result for every data operation up to DEY
    if (i_mode <= cpualu_pkg::OP_DEY) begin
      p[cpualu_pkg::FLAG_Z] = (res == 8'd0);
      p[cpualu_pkg::FLAG_N] = res[7];
    end
    // BIT takes N and V from the operand
    if (i_mode == cpualu_pkg::OP_BIT) begin
      p[cpualu_pkg::FLAG_V] = i_operand[6];
      p[cpualu_pkg::FLAG_N] = i_operand[7];
    end
    p[cpualu_pkg::FLAG_U] = 1'b1;
    st.status = p;

    o_state            = st;
    o_res.result       = res;
    o_res.write_memory = wr;
    o_res.branch_taken = br;
    o_res.status_out   = p;
  end

endmodule
`default_nettype wire

### src/eight_bit_cpu_alu_flags_top.sv
// Top level: input register, execute logic, register file and result register.
// Path: a request is held in the input register and its result in the result
// register, which holds it while the receiver stalls.
// Throughput: one request per cycle unless the receiver stalls; the register file updates as a request
// moves from the input register into the result register.
// Reset (synchronous, rst_n low): A, X, Y cleared, status 0x20, both stages empty.
`timescale 1ns / 1ps
`default_nettype none
module eight_bit_cpu_alu_flags_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [5:0] in_mode,
  input  wire logic [7:0] in_operand,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_result,
  output logic            out_write_memory,
  output logic            out_branch_taken,
  output logic [7:0]      out_status_out
);

  logic                    s1_valid_r;
  logic [5:0]              s1_mode_r;
  logic [7:0]              s1_operand_r;
  cpualu_pkg::arch_state_t st_r;
  cpualu_pkg::arch_state_t st_nxt;
  cpualu_pkg::exec_res_t   res_nxt;
  cpualu_pkg::exec_res_t   res_r;
  logic                    out_valid_r;
  logic                    out_free;
  logic                    s1_adv;

  // Handshake control
  assign out_free = ~out_valid_r | ~out_stall;
  assign s1_adv   = s1_valid_r & out_free;
  assign in_stall = s1_valid_r & ~out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_mode_r    <= in_mode;
      s1_operand_r <= in_operand;
    end
  end

  cpualu_exec u_exec (
    .i_mode    (s1_mode_r),
    .i_operand (s1_operand_r),
    .i_state   (st_r),
    .o_state   (st_nxt),
    .o_res     (res_nxt)
  );

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.accum   <= 8'd0;
      st_r.index_x <= 8'd0;
      st_r.index_y <= 8'd0;
      st_r.status  <= cpualu_pkg::STATUS_RESET;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result       = res_r.result;
  assign out_write_memory = res_r.write_memory;
  assign out_branch_taken = res_r.branch_taken;
  assign out_status_out   = res_r.status_out;

endmodule
`default_nettype wire

### src/cpualu_checker.sv
// Checker on the top level ports, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cpualu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [5:0] in_mode,
  input wire logic [7:0] in_operand,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_result,
  input wire logic       out_write_memory,
  input wire logic       out_branch_taken,
  input wire logic [7:0] out_status_out
);

  // Nothing pending straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Fixed status bits: bit 5 set, B never set
  a_status_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status_out[5] && !out_status_out[4]))
    else $error("fixed status bits wrong");

  // A taken branch gives a zero result and never a memory write
  a_branch_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_branch_taken) |-> (out_result == 8'd0 && !out_write_memory))
    else $error("taken branch with result or write");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result)
      && $stable(out_status_out)))
    else $error("stalled result changed");

  // A stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_mode)
      && $stable(in_operand)))
    else $error("stalled request changed");

endmodule

bind eight_bit_cpu_alu_flags_top cpualu_checker u_cpualu_checker (.*);
`default_nettype wire

### test/tb_eight_bit_cpu_alu_flags_top.sv
// Testbench for the CPU execute unit: directed and random requests against a shadow model.
`timescale 1ns / 1ps
module tb_eight_bit_cpu_alu_flags_top;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [5:0] in_mode = '0;
  logic [7:0] in_operand = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_result;
  logic       out_write_memory;
  logic       out_branch_taken;
  logic [7:0] out_status_out;

  // Shadow architectural registers
  logic [7:0] sh_a = 8'h00;
  logic [7:0] sh_x = 8'h00;
  logic [7:0] sh_y = 8'h00;
  logic [7:0] sh_p = cpualu_pkg::STATUS_RESET;

  cpualu_pkg::exec_res_t pending_results[$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;

  eight_bit_cpu_alu_flags_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_operand       (in_operand),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result       (out_result),
    .out_write_memory (out_write_memory),
    .out_branch_taken (out_branch_taken),
    .out_status_out   (out_status_out)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow execute unit
  // ---------------------------------------------------------------------------
  function automatic void set_nz(input logic [7:0] v);
    sh_p[cpualu_pkg::FLAG_Z] = (v == 8'h00);
    sh_p[cpualu_pkg::FLAG_N] = v[7];
  endfunction

  // Binary add with carry in; SBC feeds the inverted operand through here
  function automatic logic [7:0] add_with_carry(input logic [7:0] a, input logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, m} + {8'h00, sh_p[cpualu_pkg::FLAG_C]};
    sh_p[cpualu_pkg::FLAG_V] = (a[7] ^ sum[7]) & (m[7] ^ sum[7]);
    sh_p[cpualu_pkg::FLAG_C] = sum[8];
    set_nz(sum[7:0]);
    return sum[7:0];
  endfunction

  function automatic logic [7:0] compare_with(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] d;
    d = r - m;
    sh_p[cpualu_pkg::FLAG_C] = (r >= m);
    set_nz(d);
    return d;
  endfunction

  function automatic cpualu_pkg::exec_res_t execute_op(input logic [5:0] op,
                                                       input logic [7:0] m);
    cpualu_pkg::exec_res_t r;
    r = '0;
    case (op)
      cpualu_pkg::OP_ADC: begin
        sh_a = add_with_carry(sh_a, m);
        r.result = sh_a;
      end
      cpualu_pkg::OP_SBC: begin
        sh_a = add_with_carry(sh_a, ~m);
        r.result = sh_a;
      end
      cpualu_pkg::OP_AND: begin
        sh_a = sh_a & m;
        set_nz(sh_a);
        r.result = sh_a;
      end
      cpualu_pkg::OP_ORA: begin
        sh_a = sh_a | m;
        set_nz(sh_a);
        r.result = sh_a;
      end
      cpualu_pkg::OP_EOR: begin
        sh_a = sh_a ^ m;
        set_nz(sh_a);
        r.result = sh_a;
      end
      // A is left alone; N and V come straight from the operand
      cpualu_pkg::OP_BIT: begin
        r.result = sh_a & m;
        sh_p[cpualu_pkg::FLAG_Z] = (r.result == 8'h00);
        sh_p[cpualu_pkg::FLAG_V] = m[6];
        sh_p[cpualu_pkg::FLAG_N] = m[7];
      end
      cpualu_pkg::OP_CMP: r.result = compare_with(sh_a, m);
      cpualu_pkg::OP_CPX: r.result = compare_with(sh_x, m);
      cpualu_pkg::OP_CPY: r.result = compare_with(sh_y, m);
      cpualu_pkg::OP_LDA: begin
        sh_a = m;
        set_nz(m);
        r.result = m;
      end
      cpualu_pkg::OP_LDX: begin
        sh_x = m;
        set_nz(m);
        r.result = m;
      end
      cpualu_pkg::OP_LDY: begin
        sh_y = m;
        set_nz(m);
        r.result = m;
      end
      cpualu_pkg::OP_ASL_A: begin
        sh_p[cpualu_pkg::FLAG_C] = sh_a[7];
        sh_a = {sh_a[6:0], 1'b0};
        set_nz(sh_a);
        r.result = sh_a;
      end
      cpualu_pkg::OP_ASL_M: begin
        sh_p[cpualu_pkg::FLAG_C] = m[7];
        r.result = {m[6:0], 1'b0};
        set_nz(r.result);
        r.write_memory = 1'b1;
      end
      cpualu_pkg::OP_LSR_A: begin
        sh_p[cpualu_pkg::FLAG_C] = sh_a[0];
        sh_a = {1'b0, sh_a[7:1]};
        set_nz(sh_a);
        r.result = sh_a;
      end
      cpualu_pkg::OP_LSR_M: begin
        sh_p[cpualu_pkg::FLAG_C] = m[0];
        r.result = {1'b0, m[7:1]};
        set_nz(r.result);
        r.write_memory = 1'b1;
      end
      cpualu_pkg::OP_INC_M: begin
        r.result = m + 8'd1;
        set_nz(r.result);
        r.write_memory = 1'b1;
      end
      cpualu_pkg::OP_DEC_M: begin
        r.result = m - 8'd1;
        set_nz(r.result);
        r.write_memory = 1'b1;
      end
      cpualu_pkg::OP_INX: begin
        sh_x = sh_x + 8'd1;
        set_nz(sh_x);
        r.result = sh_x;
      end
      cpualu_pkg::OP_INY: begin
        sh_y = sh_y + 8'd1;
        set_nz(sh_y);
        r.result = sh_y;
      end
      cpualu_pkg::OP_DEX: begin
        sh_x = sh_x - 8'd1;
        set_nz(sh_x);
        r.result = sh_x;
      end
      cpualu_pkg::OP_DEY: begin
        sh_y = sh_y - 8'd1;
        set_nz(sh_y);
        r.result = sh_y;
      end
      cpualu_pkg::OP_CLC: sh_p[cpualu_pkg::FLAG_C] = 1'b0;
      cpualu_pkg::OP_CLD: sh_p[cpualu_pkg::FLAG_D] = 1'b0;
      cpualu_pkg::OP_CLI: sh_p[cpualu_pkg::FLAG_I] = 1'b0;
      cpualu_pkg::OP_CLV: sh_p[cpualu_pkg::FLAG_V] = 1'b0;
      cpualu_pkg::OP_BPL: r.branch_taken = !sh_p[cpualu_pkg::FLAG_N];
      cpualu_pkg::OP_BMI: r.branch_taken = sh_p[cpualu_pkg::FLAG_N];
      cpualu_pkg::OP_BVC: r.branch_taken = !sh_p[cpualu_pkg::FLAG_V];
      cpualu_pkg::OP_BVS: r.branch_taken = sh_p[cpualu_pkg::FLAG_V];
      cpualu_pkg::OP_BCC: r.branch_taken = !sh_p[cpualu_pkg::FLAG_C];
      cpualu_pkg::OP_BCS: r.branch_taken = sh_p[cpualu_pkg::FLAG_C];
      cpualu_pkg::OP_BNE: r.branch_taken = !sh_p[cpualu_pkg::FLAG_Z];
      cpualu_pkg::OP_BEQ: r.branch_taken = sh_p[cpualu_pkg::FLAG_Z];
      // unused codes: nothing changes
      default: ;
    endcase
    sh_p[cpualu_pkg::FLAG_U] = 1'b1;
    r.status_out = sh_p;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request acceptance, result checking and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    cpualu_pkg::exec_res_t want;
    logic      moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      pending_results.push_back(execute_op(in_mode, in_operand));
      moved = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: out_result %h, out_status_out %h",
               out_result, out_status_out);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_result !== want.result) begin
          $error("out_result: expected %h, actual %h", want.result, out_result);
          fail_count++;
        end
        if (out_write_memory !== want.write_memory) begin
          $error("out_write_memory: expected %b, actual %b",
                 want.write_memory, out_write_memory);
          fail_count++;
        end
        if (out_branch_taken !== want.branch_taken) begin
          $error("out_branch_taken: expected %b, actual %b",
                 want.branch_taken, out_branch_taken);
          fail_count++;
        end
        if (out_status_out !== want.status_out) begin
          $error("out_status_out: expected %h, actual %h", want.status_out, out_status_out);
          fail_count++;
        end
      end
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("eight_bit_cpu_alu_flags_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: five stall styles, each kept for a randomly drawn count of cycles
  // ---------------------------------------------------------------------------
  int stall_style = 0;
  int stall_left = 0;
  int stall_cyc = 0;

  always @(posedge clk) begin
    stall_cyc++;
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 4);
      stall_left = $urandom_range(50, 300);
    end else begin
      stall_left--;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      3: out_stall <= ((stall_cyc % 3) == 0);
      default: out_stall <= ((stall_cyc % 32) < 12);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of requests with random gaps between them
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [5:0] op, input logic [7:0] m);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_mode    <= op;
    in_operand <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Operand with the byte corners well represented
  function automatic logic [7:0] pick_operand();
    logic [7:0] corners [5];
    corners = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 4) == 0) return corners[3'($urandom_range(0, 4))];
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  // Carry and signed overflow in both directions
  task automatic test_add_sub_flags();
    send_request(cpualu_pkg::OP_LDA, 8'h7F);
    send_request(cpualu_pkg::OP_ADC, 8'h01);
    send_request(cpualu_pkg::OP_ADC, 8'hFF);
    send_request(cpualu_pkg::OP_SBC, 8'hFF);
    send_request(cpualu_pkg::OP_SBC, 8'h00);
  endtask

  // Logic ops and BIT, which must not touch A
  task automatic test_logic_and_bit();
    send_request(cpualu_pkg::OP_AND, 8'hFF);
    send_request(cpualu_pkg::OP_EOR, 8'hFF);
    send_request(cpualu_pkg::OP_ORA, 8'h00);
    send_request(cpualu_pkg::OP_BIT, 8'hC0);
    send_request(cpualu_pkg::OP_BIT, 8'h00);
  endtask

  // Loads and compares: equal and less
  task automatic test_load_and_compare();
    send_request(cpualu_pkg::OP_LDX, 8'hFF);
    send_request(cpualu_pkg::OP_LDY, 8'h00);
    send_request(cpualu_pkg::OP_CMP, 8'hFF);
    send_request(cpualu_pkg::OP_CPX, 8'hFF);
    send_request(cpualu_pkg::OP_CPY, 8'h01);
  endtask

  // Shifts on A ignore the operand; memory forms raise the write strobe
  task automatic test_shift_and_step();
    send_request(cpualu_pkg::OP_ASL_A, 8'hA5);
    send_request(cpualu_pkg::OP_ASL_M, 8'h80);
    send_request(cpualu_pkg::OP_LSR_A, 8'h5A);
    send_request(cpualu_pkg::OP_LSR_M, 8'h01);
    send_request(cpualu_pkg::OP_INC_M, 8'hFF);
    send_request(cpualu_pkg::OP_DEC_M, 8'h00);
    send_request(cpualu_pkg::OP_INX, 8'hFF);
    send_request(cpualu_pkg::OP_INY, 8'h00);
    send_request(cpualu_pkg::OP_DEX, 8'h80);
    send_request(cpualu_pkg::OP_DEY, 8'h7F);
  endtask

  // Every branch condition, the flag clears, then branches again on cleared flags
  task automatic test_clear_and_branch();
    logic [5:0] op;
    send_request(cpualu_pkg::OP_LDA, 8'h80);
    send_request(cpualu_pkg::OP_ADC, 8'h80);
    for (int i = cpualu_pkg::OP_BPL; i <= cpualu_pkg::OP_BEQ; i++) begin
      op = 6'(i);
      send_request(op, pick_operand());
    end
    send_request(cpualu_pkg::OP_CLC, 8'hFF);
    send_request(cpualu_pkg::OP_CLD, 8'h00);
    send_request(cpualu_pkg::OP_CLI, 8'h00);
    send_request(cpualu_pkg::OP_CLV, 8'h00);
    send_request(cpualu_pkg::OP_BVS, 8'h00);
    send_request(cpualu_pkg::OP_BCS, 8'h00);
  endtask

  // Codes past the last operation leave everything as it was
  task automatic test_unused_codes();
    send_request(6'd34, 8'hFF);
    send_request(6'd63, 8'h00);
  endtask

  // ---------------------------------------------------------------------------
  // Random tests
  // ---------------------------------------------------------------------------
  // Any operation with any operand, unused codes sprinkled in
  task automatic test_random_mix(input int n);
    int done;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 11) == 0) begin
        send_request(6'($urandom_range(34, 63)), pick_operand());
      end else begin
        send_request(6'($urandom_range(cpualu_pkg::OP_ADC, cpualu_pkg::OP_BEQ)),
                     pick_operand());
        done++;
      end
    end
  endtask

  // Load, sometimes a CLC, a run of add/subtract with carry ripple, then a flag branch
  task automatic test_carry_chains(input int n);
    int done;
    int run;
    done = 0;
    while (done < n) begin
      send_request(cpualu_pkg::OP_LDA, pick_operand());
      if ($urandom_range(0, 2) == 0) send_request(cpualu_pkg::OP_CLC, pick_operand());
      run = $urandom_range(2, 8);
      repeat (run) begin
        send_request($urandom_range(0, 1) ? cpualu_pkg::OP_ADC : cpualu_pkg::OP_SBC,
                     pick_operand());
      end
      send_request(6'($urandom_range(cpualu_pkg::OP_BPL, cpualu_pkg::OP_BEQ)),
                   pick_operand());
      done += run + 2;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_add_sub_flags();
    test_logic_and_bit();
    test_load_and_compare();
    test_shift_and_step();
    test_clear_and_branch();
    test_unused_codes();
    test_random_mix(1200);
    test_carry_chains(300);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("eight_bit_cpu_alu_flags_top regression: pass");
    end else begin
      $display("eight_bit_cpu_alu_flags_top regression: fail");
    end
    $finish;
  end

endmodule
